>>> rtl/rbm_pkg.sv
`timescale 1ns / 1ps
// Package for the RGB blend mode unit: mode codes, control struct,
// pipeline constants and the divide-by-255 helper. No dependencies.

package rbm_pkg;

	// Channel and weight widths
	localparam int unsigned CH_W        = 8;
	localparam int unsigned WEIGHT_W    = 9;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

	// Pipeline shape: one input stage, the divider stages, three math stages
	localparam int unsigned DIV_STAGES  = 4;
	localparam int unsigned DIV_STEPS   = CH_W / DIV_STAGES;
	localparam int unsigned NUM_STAGES  = DIV_STAGES + 4;

	// Blend mode codes as carried on tuser
	typedef enum logic [2:0] {
		MODE_ADD     = 3'd0,
		MODE_SUB     = 3'd1,
		MODE_MUL     = 3'd2,
		MODE_DIV     = 3'd3,
		MODE_MIX     = 3'd4,
		MODE_LIGHT   = 3'd5,
		MODE_DARK    = 3'd6,
		MODE_ILLEGAL = 3'd7
	} mode_t;

	// Per-item control that travels beside the channel data
	typedef struct packed {
		mode_t               mode;
		logic [WEIGHT_W-1:0] weight;   // already clamped to 0..256
	} ctrl_t;

	// floor(x / 255), exact for x up to 65279
	function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return t[15:8];
	endfunction

endpackage

>>> rtl/rgb_blend_mode_unit.sv
`timescale 1ns / 1ps
// Top level of the RGB blend mode unit: input stage, valid pipeline,
// three channel datapaths. Depends on rbm_pkg and rbm_channel.
//
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   blend_weight[8:0], first_red/green/blue,            func[2:0]
//                second_red/green/blue (8 each), zero pad to 64
// m_axis    out  out_red, out_green, out_blue (8 each)               bad_mode
//
// One item per clock sustained while the output is not stalled; eight register
// stages (input register, four 2-bit divider stages, three math stages) lie
// between s_axis_tdata and m_axis_tdata.
// Reset clears only the valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; s_axis_tready drops only then.

module rgb_blend_mode_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // blend_weight, first_red, first_green, first_blue,
	                                    // second_red, second_green, second_blue, pad
	input  logic [2:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
	output logic        m_axis_tuser    // bad_mode
);
	import rbm_pkg::*;

	logic advance;

	logic [NUM_STAGES:1] valid_s;
	logic [NUM_STAGES:1] bad_s;

	// Whole pipeline moves unless the output item is held
	assign advance       = !valid_s[NUM_STAGES] || m_axis_tready;
	assign s_axis_tready = advance;

	// Valid and bad-mode shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (advance) begin
			valid_s <= {valid_s[NUM_STAGES-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bad_s <= {bad_s[NUM_STAGES-1:1], mode_t'(s_axis_tuser) == MODE_ILLEGAL};
		end
	end

	// Stage 1: input register with weight clamp
	ctrl_t           ctrl_s1;
	logic [CH_W-1:0] a_s1 [3];
	logic [CH_W-1:0] b_s1 [3];
	logic [WEIGHT_W-1:0] w_in;

	assign w_in = s_axis_tdata[8:0];

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_s1.mode   <= mode_t'(s_axis_tuser);
			ctrl_s1.weight <= (w_in > WEIGHT_ONE) ? WEIGHT_ONE : w_in;
			for (int c = 0; c < 3; c++) begin
				a_s1[c] <= s_axis_tdata[9 + c*CH_W +: CH_W];
				b_s1[c] <= s_axis_tdata[33 + c*CH_W +: CH_W];
			end
		end
	end

	// Channel datapaths: red, green, blue
	logic [CH_W-1:0] res [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		rbm_channel u_ch (
			.clk     (clk),
			.en      (advance),
			.ctrl_in (ctrl_s1),
			.a_in    (a_s1[c]),
			.b_in    (b_s1[c]),
			.res     (res[c])
		);
	end

	assign m_axis_tvalid = valid_s[NUM_STAGES];
	assign m_axis_tdata  = {res[2], res[1], res[0]};
	assign m_axis_tuser  = bad_s[NUM_STAGES];

	// Illegal mode always comes out as black
	a_bad_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("bad_mode item with nonzero color");

	// A stall freezes every valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(valid_s))
		else $error("pipeline moved during stall");

	// Accepted item lands in stage 1 with its mode flag
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=>
			valid_s[1] && (bad_s[1] == ($past(s_axis_tuser) == MODE_ILLEGAL)))
		else $error("accepted item missing from stage 1");

endmodule

>>> rtl/rbm_div_stage.sv
`timescale 1ns / 1ps
// One registered stage of the 8-bit restoring divider: two quotient bits.
// Depends on rbm_pkg.

module rbm_div_stage (
	input  logic                     clk,
	input  logic                     en,
	input  logic [rbm_pkg::CH_W-1:0] rem_in,
	input  logic [rbm_pkg::CH_W-1:0] quo_in,   // dividend bits left, quotient bits shifted in
	input  logic [rbm_pkg::CH_W-1:0] den_in,
	output logic [rbm_pkg::CH_W-1:0] rem_out,
	output logic [rbm_pkg::CH_W-1:0] quo_out,
	output logic [rbm_pkg::CH_W-1:0] den_out
);
	import rbm_pkg::*;

	logic [CH_W-1:0] rem_nxt;
	logic [CH_W-1:0] quo_nxt;

	// Shift-compare-subtract, DIV_STEPS times
	always_comb begin
		logic [CH_W:0]   trial;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] q;
		r = rem_in;
		q = quo_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {r, q[CH_W-1]};
			q     = {q[CH_W-2:0], 1'b0};
			if (trial >= {1'b0, den_in}) begin
				trial = trial - {1'b0, den_in};
				q[0]  = 1'b1;
			end
			r = trial[CH_W-1:0];
		end
		rem_nxt = r;
		quo_nxt = q;
	end

	// Stage register, held on stall
	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_nxt;
			quo_out <= quo_nxt;
			den_out <= den_in;
		end
	end

endmodule

>>> rtl/rbm_channel.sv
`timescale 1ns / 1ps
// Datapath of one color channel, stages 2 to 8: divider, products, sums,
// divide by 255 and final select. Depends on rbm_pkg and rbm_div_stage.

module rbm_channel (
	input  logic                     clk,
	input  logic                     en,
	input  rbm_pkg::ctrl_t           ctrl_in,
	input  logic [rbm_pkg::CH_W-1:0] a_in,
	input  logic [rbm_pkg::CH_W-1:0] b_in,
	output logic [rbm_pkg::CH_W-1:0] res
);
	import rbm_pkg::*;

	typedef struct packed {
		ctrl_t           ctrl;
		logic [CH_W-1:0] a;
	} carry_t;

	// Divider chain, stages 2..5
	logic [CH_W-1:0] rem_s [DIV_STAGES+1];
	logic [CH_W-1:0] quo_s [DIV_STAGES+1];
	logic [CH_W-1:0] den_s [DIV_STAGES+1];

	assign rem_s[0] = '0;
	assign quo_s[0] = a_in;
	assign den_s[0] = b_in;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		rbm_div_stage u_div (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_s[g]),
			.quo_in  (quo_s[g]),
			.den_in  (den_s[g]),
			.rem_out (rem_s[g+1]),
			.quo_out (quo_s[g+1]),
			.den_out (den_s[g+1])
		);
	end

	// Control and A ride beside the divider, one register per divider stage
	carry_t carry_s [2:DIV_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s[2] <= '{ctrl: ctrl_in, a: a_in};
			for (int i = 3; i <= int'(DIV_STAGES) + 1; i++) begin
				carry_s[i] <= carry_s[i-1];
			end
		end
	end

	// Stage 6: operand select and products
	logic [CH_W-1:0]     a5, b5, v5;
	logic [WEIGHT_W-1:0] w5, w_inv5;

	assign a5     = carry_s[DIV_STAGES+1].a;
	assign b5     = den_s[DIV_STAGES];
	assign w5     = carry_s[DIV_STAGES+1].ctrl.weight;
	assign w_inv5 = WEIGHT_ONE - w5;

	always_comb begin
		case (carry_s[DIV_STAGES+1].ctrl.mode)
			MODE_DIV:   v5 = quo_s[DIV_STAGES];
			MODE_LIGHT: v5 = (a5 > b5) ? a5 : b5;
			MODE_DARK:  v5 = (a5 < b5) ? a5 : b5;
			default:    v5 = b5;
		endcase
	end

	carry_t      carry_s6;
	logic [15:0] p_aw_s6, p_vw_s6, p_ab_s6;
	logic        b_zero_s6, b_ge_a_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s6  <= carry_s[DIV_STAGES+1];
			p_aw_s6   <= 16'({8'd0, a5} * {7'd0, w_inv5});
			p_vw_s6   <= 16'({8'd0, v5} * {7'd0, w5});
			p_ab_s6   <= 16'({8'd0, a5} * {8'd0, b5});
			b_zero_s6 <= (b5 == '0);
			b_ge_a_s6 <= (b5 >= a5);
		end
	end

	// Stage 7: weighted sums; multiply mode keeps its numerator
	logic [16:0]     mix_sum, add_sum;
	logic [15:0]     sub_diff;
	logic [23:0]     mul_num;
	logic [CH_W-1:0] res6;

	assign mix_sum  = {1'b0, p_aw_s6} + {1'b0, p_vw_s6};
	assign add_sum  = {1'b0, carry_s6.a, 8'd0} + {1'b0, p_vw_s6};
	assign sub_diff = {carry_s6.a, 8'd0} - p_vw_s6;
	assign mul_num  = {p_aw_s6, 8'd0} - {8'd0, p_aw_s6}
		+ 24'({8'd0, p_ab_s6} * {15'd0, carry_s6.ctrl.weight});

	always_comb begin
		case (carry_s6.ctrl.mode)
			MODE_ADD: res6 = add_sum[16] ? 8'd255 : add_sum[15:8];
			MODE_SUB: res6 = b_ge_a_s6 ? 8'd0 : sub_diff[15:8];
			MODE_DIV: res6 = b_zero_s6 ? 8'd255 : mix_sum[15:8];
			default:  res6 = mix_sum[15:8];
		endcase
	end

	carry_t          carry_s7;
	logic [CH_W-1:0] res_s7;
	logic [23:0]     mul_num_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s7   <= carry_s6;
			res_s7     <= res6;
			mul_num_s7 <= mul_num;
		end
	end

	// Stage 8: divide by 255*256, overrides, output register
	logic [CH_W-1:0] res7;

	always_comb begin
		if (carry_s7.ctrl.mode == MODE_ILLEGAL) begin
			res7 = '0;
		end else if (carry_s7.ctrl.weight == '0) begin
			res7 = carry_s7.a;
		end else if (carry_s7.ctrl.mode == MODE_MUL) begin
			res7 = div255(mul_num_s7[23:8]);
		end else begin
			res7 = res_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res7;
		end
	end

endmodule
